// File: src/pfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_pkg: shared types and constants of the plotter path fit scaler
// Fixed point formats, opcodes, command kinds, register indexes, beat
// structs, the controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package pfs_pkg;

    // Coordinates are signed Q15.8 millimetres; the scale is signed Q7.16.
    localparam int COORD_W    = 24;
    localparam int COORD_FRAC = 8;
    localparam int SCALE_FRAC = 16;
    localparam int SCALE_W    = SCALE_FRAC + 8;
    localparam int MARGIN_W   = COORD_W - 1;

    localparam int OP_W      = 3;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = COORD_W;

    // Derived datapath widths.
    localparam int DIFF_W    = COORD_W + 1;            // point minus box corner
    localparam int TGT_W     = COORD_W + 3;            // area span less margins
    localparam int DVD_W     = TGT_W + SCALE_FRAC;     // divider dividend
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);
    localparam int PROD_W    = DIFF_W + SCALE_W;       // offset times scale
    localparam int QUO_W     = PROD_W - SCALE_FRAC;    // product in coordinates
    localparam int SUM_W     = QUO_W + 2;              // plus margin and edge

    // Reset values of the registers and of the scale.
    localparam logic signed [COORD_W-1:0] AREA_LOW_RESET  = '0;
    localparam logic signed [COORD_W-1:0] AREA_HIGH_RESET =
        COORD_W'(200 * (1 << COORD_FRAC));
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(10 * (1 << COORD_FRAC));
    localparam logic signed [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1 << SCALE_FRAC);
    localparam logic signed [SCALE_W-1:0] SCALE_MAX = {1'b0, {(SCALE_W-1){1'b1}}};
    localparam logic signed [SCALE_W-1:0] SCALE_MIN = {1'b1, {(SCALE_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_BEGIN    = 3'd0,
        OP_MEASURE  = 3'd1,
        OP_FINISH   = 3'd2,
        OP_DRAW     = 3'd3,
        OP_END_PATH = 3'd4
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PEN_UP    = 2'd0,
        KIND_PEN_DOWN  = 2'd1,
        KIND_MOVE      = 2'd2,
        KIND_NO_POINTS = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AREA_X_LOW  = 3'd0,
        CFG_AREA_X_HIGH = 3'd1,
        CFG_AREA_Y_LOW  = 3'd2,
        CFG_AREA_Y_HIGH = 3'd3,
        CFG_EDGE_MARGIN = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [OP_W-1:0]           opcode;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } in_beat_t;

    typedef struct packed {
        logic [KIND_W-1:0]         command_kind;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic                      last_of_run;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ERROR,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_MUL_X,
        ST_MUL_Y,
        ST_FIX,
        ST_PEN,
        ST_MOVE,
        ST_LIFT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  capture;
        logic  clear_box;
        logic  measure;
        logic  set_centre;
        logic  div_start;
        logic  div_sel_y;
        logic  take_sx;
        logic  take_scale;
        logic  mul_x;
        logic  mul_y;
        logic  fix;
        logic  emit;
        kind_t emit_kind;
        logic  emit_last;
        logic  open_path;
        logic  close_path;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            seen_any;
        logic            path_open;
        logic            box_flat;
        logic            div_done;
        logic            out_free;
    } ctrl_status_t;

endpackage

// File: src/pfs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_div: iterative scale divider
// Restoring division, one quotient bit per cycle, of a signed span shifted
// up by the scale fraction over a positive box size. The quotient is
// truncated toward zero and saturated to the signed scale width.
// ----------------------------------------------------------------------------
module pfs_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [pfs_pkg::TGT_W-1:0]     numer,
    input  logic [pfs_pkg::COORD_W-1:0]          denom,
    output logic                                 done,
    output logic signed [pfs_pkg::SCALE_W-1:0]   quot
);

    localparam logic [pfs_pkg::DVD_W-1:0] QUO_POS_MAX =
        pfs_pkg::DVD_W'(pfs_pkg::SCALE_MAX);
    localparam logic [pfs_pkg::DVD_W-1:0] QUO_NEG_MAX =
        pfs_pkg::DVD_W'(1) << (pfs_pkg::SCALE_W - 1);

    logic                                busy_reg;
    logic                                done_reg;
    logic [pfs_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic                                neg_reg;
    logic [pfs_pkg::DVD_W-1:0]           dvd_reg;
    logic [pfs_pkg::DVD_W-1:0]           quo_reg;
    logic [pfs_pkg::COORD_W-1:0]         rem_reg;
    logic [pfs_pkg::COORD_W-1:0]         den_reg;
    logic signed [pfs_pkg::SCALE_W-1:0]  quot_reg;

    logic [pfs_pkg::COORD_W:0]           rem_sh;
    logic [pfs_pkg::COORD_W:0]           rem_sub;
    logic                                fits;
    logic [pfs_pkg::TGT_W-1:0]           numer_mag;
    logic signed [pfs_pkg::SCALE_W-1:0]  quot_sat;

    // One restoring step and the final sign and saturation.
    always_comb begin
        rem_sh    = {rem_reg, dvd_reg[pfs_pkg::DVD_W-1]};
        fits      = rem_sh >= {1'b0, den_reg};
        rem_sub   = rem_sh - {1'b0, den_reg};
        numer_mag = numer[pfs_pkg::TGT_W-1] ? pfs_pkg::TGT_W'(-numer)
                                            : pfs_pkg::TGT_W'(numer);
        if (neg_reg) begin
            if (quo_reg > QUO_NEG_MAX) begin
                quot_sat = pfs_pkg::SCALE_MIN;
            end else begin
                quot_sat = -$signed(quo_reg[pfs_pkg::SCALE_W-1:0]);
            end
        end else begin
            if (quo_reg > QUO_POS_MAX) begin
                quot_sat = pfs_pkg::SCALE_MAX;
            end else begin
                quot_sat = $signed(quo_reg[pfs_pkg::SCALE_W-1:0]);
            end
        end
    end

    // Control: a count of remaining steps, then a finishing step that raises done.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= pfs_pkg::DIV_CNT_W'(pfs_pkg::DVD_W);
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - pfs_pkg::DIV_CNT_W'(1);
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and partial results.
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {numer_mag, {pfs_pkg::SCALE_FRAC{1'b0}}};
            quo_reg <= '0;
            rem_reg <= '0;
            neg_reg <= numer[pfs_pkg::TGT_W-1];
            den_reg <= denom;
        end else if (busy_reg && cnt_reg != '0) begin
            dvd_reg <= {dvd_reg[pfs_pkg::DVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[pfs_pkg::DVD_W-2:0], fits};
            rem_reg <= fits ? rem_sub[pfs_pkg::COORD_W-1:0]
                            : rem_sh[pfs_pkg::COORD_W-1:0];
        end else if (busy_reg) begin
            quot_reg <= quot_sat;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: src/pfs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_datapath: registers and arithmetic of the path fit scaler
// Holds the area registers, the bounding box, the scale and the path flag,
// runs the divider and the shared multiplier, places and clamps targets and
// owns the output register.
// ----------------------------------------------------------------------------
module pfs_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pfs_pkg::ctrl_cmd_t                cmd,
    output pfs_pkg::ctrl_status_t             status,
    input  pfs_pkg::in_beat_t                 s_data,
    input  logic                              m_ready,
    output logic                              m_valid,
    output pfs_pkg::out_beat_t                m_data,
    input  logic                              cfg_wr_en,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int CW = pfs_pkg::COORD_W;

    logic signed [CW-1:0]                area_x_low_reg;
    logic signed [CW-1:0]                area_x_high_reg;
    logic signed [CW-1:0]                area_y_low_reg;
    logic signed [CW-1:0]                area_y_high_reg;
    logic [pfs_pkg::MARGIN_W-1:0]        margin_reg;

    pfs_pkg::in_beat_t                   in_reg;
    logic                                seen_any_reg;
    logic                                centre_reg;
    logic                                path_open_reg;
    logic signed [CW-1:0]                min_x_reg;
    logic signed [CW-1:0]                max_x_reg;
    logic signed [CW-1:0]                min_y_reg;
    logic signed [CW-1:0]                max_y_reg;
    logic signed [pfs_pkg::SCALE_W-1:0]  scale_reg;
    logic signed [pfs_pkg::SCALE_W-1:0]  sx_reg;
    logic signed [pfs_pkg::PROD_W-1:0]   prod_x_reg;
    logic signed [pfs_pkg::PROD_W-1:0]   prod_y_reg;
    logic signed [CW-1:0]                tx_reg;
    logic signed [CW-1:0]                ty_reg;
    logic                                out_valid_reg;
    pfs_pkg::out_beat_t                  out_reg;

    logic signed [pfs_pkg::TGT_W-1:0]    div_numer;
    logic [CW-1:0]                       div_denom;
    logic                                div_done;
    logic signed [pfs_pkg::SCALE_W-1:0]  div_quot;
    logic signed [pfs_pkg::DIFF_W-1:0]   mul_d;
    logic signed [pfs_pkg::PROD_W-1:0]   mul_p;
    logic signed [CW-1:0]                tx_next;
    logic signed [CW-1:0]                ty_next;
    logic                                out_free;

    // Scaled offset truncated toward zero, plus margin and low edge, or the
    // area centre in centre mode; then clamped to the area.
    function automatic logic signed [CW-1:0] place_fix(
        input logic signed [pfs_pkg::PROD_W-1:0] prod,
        input logic signed [CW-1:0]              lo,
        input logic signed [CW-1:0]              hi,
        input logic [pfs_pkg::MARGIN_W-1:0]      margin,
        input logic                              centre
    );
        logic signed [pfs_pkg::QUO_W-1:0]  q;
        logic signed [pfs_pkg::DIFF_W-1:0] mid_sum;
        logic signed [pfs_pkg::SUM_W-1:0]  v;
        logic signed [pfs_pkg::SUM_W-1:0]  lo_ext;
        logic signed [pfs_pkg::SUM_W-1:0]  hi_ext;
        q = prod[pfs_pkg::PROD_W-1:pfs_pkg::SCALE_FRAC];
        if (prod[pfs_pkg::PROD_W-1] && (prod[pfs_pkg::SCALE_FRAC-1:0] != '0)) begin
            q = q + pfs_pkg::QUO_W'(1);
        end
        mid_sum = pfs_pkg::DIFF_W'(lo) + pfs_pkg::DIFF_W'(hi);
        if (mid_sum[pfs_pkg::DIFF_W-1]) begin
            mid_sum = mid_sum + pfs_pkg::DIFF_W'(1);
        end
        lo_ext = pfs_pkg::SUM_W'(lo);
        hi_ext = pfs_pkg::SUM_W'(hi);
        if (centre) begin
            v = pfs_pkg::SUM_W'(mid_sum >>> 1);
        end else begin
            v = pfs_pkg::SUM_W'(q) + pfs_pkg::SUM_W'({1'b0, margin}) + lo_ext;
        end
        if (v < lo_ext) begin
            return lo;
        end else if (v > hi_ext) begin
            return hi;
        end
        return v[CW-1:0];
    endfunction

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_x_low_reg  <= pfs_pkg::AREA_LOW_RESET;
            area_x_high_reg <= pfs_pkg::AREA_HIGH_RESET;
            area_y_low_reg  <= pfs_pkg::AREA_LOW_RESET;
            area_y_high_reg <= pfs_pkg::AREA_HIGH_RESET;
            margin_reg      <= pfs_pkg::MARGIN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pfs_pkg::CFG_AREA_X_LOW:  area_x_low_reg  <= cfg_wdata;
                pfs_pkg::CFG_AREA_X_HIGH: area_x_high_reg <= cfg_wdata;
                pfs_pkg::CFG_AREA_Y_LOW:  area_y_low_reg  <= cfg_wdata;
                pfs_pkg::CFG_AREA_Y_HIGH: area_y_high_reg <= cfg_wdata;
                pfs_pkg::CFG_EDGE_MARGIN: margin_reg <= cfg_wdata[pfs_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Divider operands: the area span less two margins over the box size.
    always_comb begin
        if (cmd.div_sel_y) begin
            div_numer = pfs_pkg::TGT_W'(area_y_high_reg) - pfs_pkg::TGT_W'(area_y_low_reg)
                      - pfs_pkg::TGT_W'({margin_reg, 1'b0});
            div_denom = max_y_reg - min_y_reg;
        end else begin
            div_numer = pfs_pkg::TGT_W'(area_x_high_reg) - pfs_pkg::TGT_W'(area_x_low_reg)
                      - pfs_pkg::TGT_W'({margin_reg, 1'b0});
            div_denom = max_x_reg - min_x_reg;
        end
    end

    pfs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .numer   (div_numer),
        .denom   (div_denom),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Shared multiplier: offset from the box corner times the scale.
    always_comb begin
        if (cmd.mul_y) begin
            mul_d = pfs_pkg::DIFF_W'(in_reg.point_y) - pfs_pkg::DIFF_W'(min_y_reg);
        end else begin
            mul_d = pfs_pkg::DIFF_W'(in_reg.point_x) - pfs_pkg::DIFF_W'(min_x_reg);
        end
        mul_p = mul_d * scale_reg;
    end

    always_comb begin
        tx_next = place_fix(prod_x_reg, area_x_low_reg, area_x_high_reg,
                            margin_reg, centre_reg);
        ty_next = place_fix(prod_y_reg, area_y_low_reg, area_y_high_reg,
                            margin_reg, centre_reg);
    end

    // Input capture and arithmetic results.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.mul_x) begin
            prod_x_reg <= mul_p;
        end
        if (cmd.mul_y) begin
            prod_y_reg <= mul_p;
        end
        if (cmd.fix) begin
            tx_reg <= tx_next;
            ty_reg <= ty_next;
        end
        if (cmd.take_sx) begin
            sx_reg <= div_quot;
        end
    end

    // Bounding box, scale and path state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_any_reg  <= 1'b0;
            centre_reg    <= 1'b0;
            path_open_reg <= 1'b0;
            min_x_reg     <= '0;
            max_x_reg     <= '0;
            min_y_reg     <= '0;
            max_y_reg     <= '0;
            scale_reg     <= pfs_pkg::SCALE_ONE;
        end else begin
            if (cmd.clear_box) begin
                seen_any_reg <= 1'b0;
                min_x_reg    <= '0;
                max_x_reg    <= '0;
                min_y_reg    <= '0;
                max_y_reg    <= '0;
            end else if (cmd.measure) begin
                seen_any_reg <= 1'b1;
                if (!seen_any_reg || in_reg.point_x < min_x_reg) begin
                    min_x_reg <= in_reg.point_x;
                end
                if (!seen_any_reg || in_reg.point_x > max_x_reg) begin
                    max_x_reg <= in_reg.point_x;
                end
                if (!seen_any_reg || in_reg.point_y < min_y_reg) begin
                    min_y_reg <= in_reg.point_y;
                end
                if (!seen_any_reg || in_reg.point_y > max_y_reg) begin
                    max_y_reg <= in_reg.point_y;
                end
            end
            if (cmd.set_centre) begin
                centre_reg <= 1'b1;
                scale_reg  <= pfs_pkg::SCALE_ONE;
            end else if (cmd.take_scale) begin
                centre_reg <= 1'b0;
                scale_reg  <= (sx_reg < div_quot) ? sx_reg : div_quot;
            end
            if (cmd.clear_box || cmd.close_path) begin
                path_open_reg <= 1'b0;
            end else if (cmd.open_path) begin
                path_open_reg <= 1'b1;
            end
        end
    end

    // Output register: a beat waits here until the sink takes it.
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.command_kind <= cmd.emit_kind;
            out_reg.last_of_run  <= cmd.emit_last;
            if (cmd.emit_kind == pfs_pkg::KIND_MOVE) begin
                out_reg.target_x <= tx_reg;
                out_reg.target_y <= ty_reg;
            end else begin
                out_reg.target_x <= '0;
                out_reg.target_y <= '0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        status.opcode    = in_reg.opcode;
        status.seen_any  = seen_any_reg;
        status.path_open = path_open_reg;
        status.box_flat  = (max_x_reg <= min_x_reg) || (max_y_reg <= min_y_reg);
        status.div_done  = div_done;
        status.out_free  = out_free;
    end

    // A move beat always follows the pen command that opened the path.
    a_move_path_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.emit_kind == pfs_pkg::KIND_MOVE) |=> path_open_reg)
        else $error("move beat issued while no path was open");

    // A measured point always leaves the box marked as holding points.
    a_measure_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.measure |=> seen_any_reg)
        else $error("box not marked after a measured point");

endmodule

// File: src/pfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_ctrl: sequencing controller of the path fit scaler
// Takes one item at a time, decodes its opcode and steps the datapath
// through the measure, divide, multiply, place and output phases.
// ----------------------------------------------------------------------------
module pfs_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  pfs_pkg::ctrl_status_t  status,
    output pfs_pkg::ctrl_cmd_t     cmd
);

    pfs_pkg::state_t state_reg;
    pfs_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit_kind = pfs_pkg::KIND_PEN_UP;
        s_ready       = (state_reg == pfs_pkg::ST_IDLE);
        unique case (state_reg)
            pfs_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = pfs_pkg::ST_DECODE;
                end
            end
            pfs_pkg::ST_DECODE: begin
                state_next = pfs_pkg::ST_IDLE;
                unique case (status.opcode)
                    pfs_pkg::OP_BEGIN:    cmd.clear_box = 1'b1;
                    pfs_pkg::OP_MEASURE:  cmd.measure = 1'b1;
                    pfs_pkg::OP_FINISH: begin
                        priority if (!status.seen_any) begin
                            state_next = pfs_pkg::ST_ERROR;
                        end else if (status.box_flat) begin
                            cmd.set_centre = 1'b1;
                        end else begin
                            state_next = pfs_pkg::ST_DIVX_GO;
                        end
                    end
                    pfs_pkg::OP_DRAW:     state_next = pfs_pkg::ST_MUL_X;
                    pfs_pkg::OP_END_PATH: begin
                        if (status.path_open) begin
                            state_next = pfs_pkg::ST_LIFT;
                        end
                    end
                    default: ;
                endcase
            end
            pfs_pkg::ST_ERROR: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = pfs_pkg::KIND_NO_POINTS;
                    cmd.emit_last = 1'b1;
                    state_next    = pfs_pkg::ST_IDLE;
                end
            end
            pfs_pkg::ST_DIVX_GO: begin
                cmd.div_start = 1'b1;
                state_next    = pfs_pkg::ST_DIVX_WAIT;
            end
            pfs_pkg::ST_DIVX_WAIT: begin
                if (status.div_done) begin
                    cmd.take_sx = 1'b1;
                    state_next  = pfs_pkg::ST_DIVY_GO;
                end
            end
            pfs_pkg::ST_DIVY_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel_y = 1'b1;
                state_next    = pfs_pkg::ST_DIVY_WAIT;
            end
            pfs_pkg::ST_DIVY_WAIT: begin
                if (status.div_done) begin
                    cmd.take_scale = 1'b1;
                    state_next     = pfs_pkg::ST_IDLE;
                end
            end
            pfs_pkg::ST_MUL_X: begin
                cmd.mul_x  = 1'b1;
                state_next = pfs_pkg::ST_MUL_Y;
            end
            pfs_pkg::ST_MUL_Y: begin
                cmd.mul_y  = 1'b1;
                state_next = pfs_pkg::ST_FIX;
            end
            pfs_pkg::ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = pfs_pkg::ST_PEN;
            end
            pfs_pkg::ST_PEN: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = status.path_open ? pfs_pkg::KIND_PEN_DOWN
                                                     : pfs_pkg::KIND_PEN_UP;
                    cmd.open_path = 1'b1;
                    state_next    = pfs_pkg::ST_MOVE;
                end
            end
            pfs_pkg::ST_MOVE: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = pfs_pkg::KIND_MOVE;
                    cmd.emit_last = 1'b1;
                    state_next    = pfs_pkg::ST_IDLE;
                end
            end
            pfs_pkg::ST_LIFT: begin
                if (status.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.emit_kind  = pfs_pkg::KIND_PEN_UP;
                    cmd.emit_last  = 1'b1;
                    cmd.close_path = 1'b1;
                    state_next     = pfs_pkg::ST_IDLE;
                end
            end
            default: state_next = pfs_pkg::ST_IDLE;
        endcase
    end

    // An accepted beat is always decoded in the following cycle.
    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == pfs_pkg::ST_DECODE))
        else $error("accepted beat not followed by decode");

    // A result is only loaded when the output register can take it.
    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("result loaded over a beat still waiting");

endmodule

// File: src/plotter_path_fit_scaler.sv
`timescale 1ns / 1ps
// Finish sets the unit scale on a flat box, gives a no-points beat with no points and,
// with a fit, takes the scale from two 43-step passes of the one-bit-per-cycle divider.
// Draw: decode, multiply x, multiply y, place, then the pen beat and the move beat;
// end path gives a pen-up beat after decode when a path is open.
// One item is in work at a time; a finished beat waits in the output register.
// Reset: synchronous, active low; control, settings, box, scale and output valid reset.
// ----------------------------------------------------------------------------
// plotter_path_fit_scaler: pen plotter path fitting and scaling
// Measures the bounding box of a drawing, fits a uniform scale into the
// drawing area less a margin and turns draw points into pen and move beats.
// ----------------------------------------------------------------------------
module plotter_path_fit_scaler (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  pfs_pkg::in_beat_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output pfs_pkg::out_beat_t                m_data,
    input  logic                              cfg_wr_en,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    pfs_pkg::ctrl_cmd_t    cmd;
    pfs_pkg::ctrl_status_t status;

    pfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pfs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for plotter_path_fit_scaler
// Streams measure and draw passes of random drawings, with noise and broken
// sequences mixed in, under several area settings and idling patterns. A
// predictor works out the expected pen and move beats, and a monitor
// compares every result beat with them field by field.
// ----------------------------------------------------------------------------
module testbench;
    import pfs_pkg::*;

    localparam int    HALF_PERIOD  = 6;
    localparam int    DRAIN_CYCLES = 150;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    PHASE_ITEMS  = 84;
    localparam int    TIMEOUT_NS   = 6_000_000;
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_beat_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_beat_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Stimulus and bookkeeping.
    in_beat_t  pending_items[$];
    out_beat_t expected_beats[$];
    int        queued_items   = 0;
    int        accepted_items = 0;
    int        fail_count     = 0;
    int        send_idle_pct  = 0;
    int        stall_pct      = 0;
    int        hold_asked     = 0;
    int        hold_served    = 0;
    int        hold_left      = 0;

    // Predictor copy of the registers and the fitting state.
    longint area_x_lo, area_x_hi, area_y_lo, area_y_hi, inset;
    bit     have_points, centred, pen_in_path;
    longint box_x_min, box_x_max, box_y_min, box_y_max, scale_q16;

    plotter_path_fit_scaler i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #(HALF_PERIOD) aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("plotter_path_fit_scaler: mismatch");
        $finish;
    end

    // Ratio of the usable span to the box size, truncated and saturated.
    function automatic longint fit_ratio(longint lo, longint hi, longint size);
        longint usable, q;
        usable = (hi - lo) - 2 * inset;
        q = (usable * (longint'(1) << SCALE_FRAC)) / size;
        if (q > longint'(SCALE_MAX)) q = longint'(SCALE_MAX);
        if (q < longint'(SCALE_MIN)) q = longint'(SCALE_MIN);
        return q;
    endfunction

    // Map one source coordinate into the area. The product stays well inside
    // 64 bits at these widths, so no overflow handling is needed here.
    function automatic longint map_coord(longint p, longint bmin, longint lo, longint hi);
        longint v;
        if (centred) begin
            v = (lo + hi) / 2;
        end else begin
            v = ((p - bmin) * scale_q16) / (longint'(1) << SCALE_FRAC) + inset + lo;
        end
        if (v < lo) begin
            v = lo;
        end else if (v > hi) begin
            v = hi;
        end
        return v;
    endfunction

    function automatic out_beat_t make_beat(kind_t kind, longint x, longint y, logic last);
        out_beat_t b;
        b.command_kind = kind;
        b.target_x     = COORD_W'(x);
        b.target_y     = COORD_W'(y);
        b.last_of_run  = last;
        return b;
    endfunction

    // Update the fitting state for one accepted beat and queue its results.
    task automatic predict_item(in_beat_t beat);
        longint px, py, sx, sy;
        px = longint'($signed(beat.point_x));
        py = longint'($signed(beat.point_y));
        case (beat.opcode)
            OP_BEGIN: begin
                have_points = 1'b0;
                pen_in_path = 1'b0;
                box_x_min = 0;
                box_x_max = 0;
                box_y_min = 0;
                box_y_max = 0;
            end
            OP_MEASURE: begin
                if (!have_points) begin
                    box_x_min = px;
                    box_x_max = px;
                    box_y_min = py;
                    box_y_max = py;
                    have_points = 1'b1;
                end else begin
                    if (px < box_x_min) box_x_min = px;
                    if (px > box_x_max) box_x_max = px;
                    if (py < box_y_min) box_y_min = py;
                    if (py > box_y_max) box_y_max = py;
                end
            end
            OP_FINISH: begin
                if (!have_points) begin
                    expected_beats.push_back(make_beat(KIND_NO_POINTS, 0, 0, 1'b1));
                end else if (box_x_max == box_x_min || box_y_max == box_y_min) begin
                    centred = 1'b1;
                    scale_q16 = longint'(1) << SCALE_FRAC;
                end else begin
                    sx = fit_ratio(area_x_lo, area_x_hi, box_x_max - box_x_min);
                    sy = fit_ratio(area_y_lo, area_y_hi, box_y_max - box_y_min);
                    centred = 1'b0;
                    scale_q16 = (sx < sy) ? sx : sy;
                end
            end
            OP_DRAW: begin
                expected_beats.push_back(make_beat(pen_in_path ? KIND_PEN_DOWN : KIND_PEN_UP,
                                                   0, 0, 1'b0));
                expected_beats.push_back(make_beat(KIND_MOVE,
                    map_coord(px, box_x_min, area_x_lo, area_x_hi),
                    map_coord(py, box_y_min, area_y_lo, area_y_hi), 1'b1));
                pen_in_path = 1'b1;
            end
            OP_END_PATH: begin
                if (pen_in_path) begin
                    pen_in_path = 1'b0;
                    expected_beats.push_back(make_beat(KIND_PEN_UP, 0, 0, 1'b1));
                end
            end
            default: begin
            end
        endcase
    endtask

    // Input driver: a new beat only once the current one has been taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_items.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Accepted input beats feed the predictor.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_item(s_data);
            accepted_items <= accepted_items + 1;
        end
    end

    // Result receiver: random stalls, plus long hold-offs on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            m_ready     <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic report_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        fail_count++;
    endtask

    // Monitor: each result beat against the oldest expectation.
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got %p", $time, m_data);
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                if (m_data.command_kind !== want.command_kind)
                    report_field("command_kind", 32'(want.command_kind),
                                 32'(m_data.command_kind));
                if (m_data.target_x !== want.target_x)
                    report_field("target_x", 32'(want.target_x), 32'(m_data.target_x));
                if (m_data.target_y !== want.target_y)
                    report_field("target_y", 32'(want.target_y), 32'(m_data.target_y));
                if (m_data.last_of_run !== want.last_of_run)
                    report_field("last_of_run", 32'(want.last_of_run),
                                 32'(m_data.last_of_run));
            end
        end
    end

    task automatic push_item(logic [OP_W-1:0] op, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y);
        in_beat_t b;
        b.opcode  = op;
        b.point_x = x;
        b.point_y = y;
        pending_items.push_back(b);
        queued_items++;
    endtask

    task automatic push_noise();
        push_item(OP_W'($urandom_range(0, 7)), COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // Register write; the block is idle whenever this is called.
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_AREA_X_LOW:  area_x_lo = longint'($signed(value));
            CFG_AREA_X_HIGH: area_x_hi = longint'($signed(value));
            CFG_AREA_Y_LOW:  area_y_lo = longint'($signed(value));
            CFG_AREA_Y_HIGH: area_y_hi = longint'($signed(value));
            CFG_EDGE_MARGIN: inset = longint'(value[MARGIN_W-1:0]);
            default: begin
            end
        endcase
    endtask

    task automatic write_all(logic [CFG_DATA_W-1:0] xl, logic [CFG_DATA_W-1:0] xh,
                             logic [CFG_DATA_W-1:0] yl, logic [CFG_DATA_W-1:0] yh,
                             logic [CFG_DATA_W-1:0] mg);
        write_reg(CFG_AREA_X_LOW, xl);
        write_reg(CFG_AREA_X_HIGH, xh);
        write_reg(CFG_AREA_Y_LOW, yl);
        write_reg(CFG_AREA_Y_HIGH, yh);
        write_reg(CFG_EDGE_MARGIN, mg);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Wait until every beat is in and every result is out, then let a
    // trailing finish (which gives no result) run to completion.
    task automatic wait_idle();
        while (accepted_items != queued_items || expected_beats.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // One drawing streamed twice: measure pass, then draw pass in paths.
    // Mostly well formed; begin, finish and end path are sometimes dropped.
    task automatic queue_drawing();
        logic signed [COORD_W-1:0] xs[12];
        logic signed [COORD_W-1:0] ys[12];
        int          n, i, len, k;
        int unsigned bx, by, mask;
        bit          flat_x, flat_y;
        n      = $urandom_range(1, 12);
        bx     = $urandom;
        by     = $urandom;
        mask   = (32'd1 << $urandom_range(0, 24)) - 1;
        flat_x = ($urandom_range(0, 7) == 0);
        flat_y = ($urandom_range(0, 7) == 0);
        for (i = 0; i < n; i++) begin
            xs[i] = COORD_W'(flat_x ? bx : bx + ($urandom & mask));
            ys[i] = COORD_W'(flat_y ? by : by + ($urandom & mask));
        end
        if ($urandom_range(0, 9) == 0) begin
            push_item(OP_BEGIN, '0, '0);
            push_item(OP_FINISH, '0, '0);
        end
        if ($urandom_range(0, 9) != 0) push_item(OP_BEGIN, COORD_W'($urandom), '0);
        for (i = 0; i < n; i++) begin
            push_item(OP_MEASURE, xs[i], ys[i]);
            if ($urandom_range(0, 19) == 0) push_noise();
        end
        if ($urandom_range(0, 9) != 0) push_item(OP_FINISH, '0, '0);
        i = 0;
        while (i < n) begin
            len = $urandom_range(1, 4);
            for (k = 0; k < len && i < n; k++) begin
                push_item(OP_DRAW, xs[i], ys[i]);
                i++;
            end
            if ($urandom_range(0, 7) == 0)
                push_item(OP_DRAW, COORD_W'($urandom), COORD_W'($urandom));
            if ($urandom_range(0, 7) != 0) push_item(OP_END_PATH, '0, '0);
            if ($urandom_range(0, 19) == 0) push_noise();
        end
    endtask

    initial begin
        int          phase, start;
        int unsigned lo;
        area_x_lo   = 0;
        area_x_hi   = 51200;
        area_y_lo   = 0;
        area_y_hi   = 51200;
        inset       = 2560;
        have_points = 1'b0;
        centred     = 1'b0;
        pen_in_path = 1'b0;
        box_x_min   = 0;
        box_x_max   = 0;
        box_y_min   = 0;
        box_y_max   = 0;
        scale_q16   = longint'(1) << SCALE_FRAC;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part under the reset settings.
        // Finish with no points measured reports the error.
        push_item(OP_FINISH, '0, '0);
        // Draw before any finish uses the reset box and unit scale.
        push_item(OP_DRAW, C_MIN, C_MAX);
        push_item(OP_END_PATH, '0, '0);
        // End of path with no open path gives nothing; unused opcodes too.
        push_item(OP_END_PATH, '0, '0);
        push_item(3'd5, C_MAX, C_MIN);
        push_item(3'd6, '0, '0);
        push_item(3'd7, C_MIN, C_MAX);
        // A box of zero width puts every point in the centre.
        push_item(OP_BEGIN, '0, '0);
        push_item(OP_MEASURE, 24'sd0, 24'sd0);
        push_item(OP_MEASURE, 24'sd0, 24'sd100);
        push_item(OP_FINISH, '0, '0);
        push_item(OP_DRAW, 24'sd5, 24'sd5);
        push_item(OP_END_PATH, '0, '0);
        // The widest possible box.
        push_item(OP_BEGIN, '0, '0);
        push_item(OP_MEASURE, C_MIN, C_MIN);
        push_item(OP_MEASURE, C_MAX, C_MAX);
        push_item(OP_FINISH, '0, '0);
        push_item(OP_DRAW, C_MIN, C_MIN);
        push_item(OP_DRAW, C_MAX, C_MAX);
        push_item(OP_END_PATH, '0, '0);
        // A one-step box saturates the scale.
        push_item(OP_BEGIN, '0, '0);
        push_item(OP_MEASURE, 24'sd10, 24'sd10);
        push_item(OP_MEASURE, 24'sd11, 24'sd11);
        push_item(OP_FINISH, '0, '0);
        push_item(OP_DRAW, 24'sd11, 24'sd11);
        wait_idle();

        // Random part: one area setting and one idling pattern per phase.
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_all(24'd0, 24'd51200, 24'd0, 24'd51200, 24'd2560);
                1: write_all(C_MIN, C_MAX, C_MIN, C_MAX, 24'd0);
                2: write_all(24'd0, 24'd51200, 24'd0, 24'd51200, {1'b0, {MARGIN_W{1'b1}}});
                3: write_all(C_MAX, C_MIN, 24'sd5000, -24'sd5000, 24'($urandom_range(0, 4096)));
                default: begin
                    lo = $urandom;
                    write_all(24'(lo),
                              24'($urandom_range(0, 1) ? lo + $urandom_range(0, 1 << 20)
                                                       : $urandom),
                              24'(lo + 24'h5a5a5),
                              24'($urandom),
                              24'($urandom_range(0, 1) ? $urandom_range(0, 8192) : $urandom));
                end
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 61; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 61; end
                default: begin send_idle_pct = 16; stall_pct = 16; end
            endcase
            start = queued_items;
            while (queued_items - start < PHASE_ITEMS) queue_drawing();
            // Long receiver hold-off while the sender keeps offering beats.
            if (phase == 0 || phase == 5) hold_asked++;
            wait_idle();
        end

        if (fail_count == 0 && expected_beats.size() == 0) begin
            $display("plotter_path_fit_scaler: match");
        end else begin
            $display("plotter_path_fit_scaler: mismatch");
        end
        $finish;
    end

endmodule
